/* sv/fptm_pkg.sv */
package fptm_pkg;

    localparam int TABLE_PAGES_DEF = 16;

    localparam int VA_W        = 48;
    localparam int PA_W        = 52;
    localparam int FLAGS_W     = 64;
    localparam int ENTRY_W     = 64;
    localparam int PAGE_OFS_W  = 12;
    localparam int FRAME_W     = PA_W - PAGE_OFS_W;
    localparam int ENTRY_IDX_W = 9;
    localparam int LEVEL_W     = 2;
    localparam int ADDED_W     = 2;
    localparam int STATUS_W    = 2;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 52;
    localparam int LIMIT_W     = 5;

    localparam logic [LIMIT_W-1:0]   POOL_LIMIT_RST = LIMIT_W'(16);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = CFG_IDX_W'(1);

    localparam logic [STATUS_W-1:0] ST_MAPPED    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = STATUS_W'(2);

    // present and writable bits of a table link entry
    localparam logic [PAGE_OFS_W-1:0] LINK_FLAGS = PAGE_OFS_W'(12'h003);

    typedef struct packed {
        logic                load_req;
        logic                sweep_en;
        logic                alloc;
        logic                link;
        logic                follow;
        logic                leaf;
        logic                finish;
        logic [STATUS_W-1:0] code;
    } t_dp_cmd;

    typedef struct packed {
        logic entry_present;
        logic pool_full;
        logic outside_pool;
        logic sweep_row_last;
        logic sweep_all_last;
        logic last_level;
        logic out_free;
    } t_dp_status;

endpackage

/* sv/fptm_ram.sv */
module fptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fptm_dp.sv */
module fptm_dp import fptm_pkg::*; #(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [VA_W-1:0]       i_virt_addr,
    input  logic [PA_W-1:0]       i_phys_addr,
    input  logic [FLAGS_W-1:0]    i_page_flags,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [ADDED_W-1:0]    o_tables_added,
    output logic [VA_W-1:0]       o_invalidate_page,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_st
);

    localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int CW    = $clog2(TABLE_PAGES + 1);
    localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int AW    = PW + ENTRY_IDX_W;
    localparam int DEPTH = TABLE_PAGES * (1 << ENTRY_IDX_W);

    logic [PA_W-1:0]     r_pool_base;
    logic [LIMIT_W-1:0]  r_pool_limit;
    logic [CW-1:0]       r_next_free;
    logic [AW-1:0]       r_sweep;
    logic [VA_W-1:0]     r_virt;
    logic [PA_W-1:0]     r_phys;
    logic [FLAGS_W-1:0]  r_flags;
    logic [LEVEL_W-1:0]  r_level;
    logic [PW-1:0]       r_table;
    logic [PW-1:0]       r_fresh;
    logic [ADDED_W-1:0]  r_added;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ADDED_W-1:0]  r_tables_added;
    logic [VA_W-1:0]     r_inval;

    logic [ENTRY_IDX_W-1:0] idx;
    logic [AW-1:0]          slot;
    logic [ENTRY_W-1:0]     rdata;
    logic [FRAME_W-1:0]     offs;
    logic [FRAME_W-1:0]     link_frame;
    logic [ENTRY_W-1:0]     link_entry;
    logic [ENTRY_W-1:0]     leaf_entry;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [ENTRY_W-1:0]     wdata;
    logic [LW-1:0]          usable;
    logic [LW-1:0]          limit_ext;
    logic [LW-1:0]          pages_ext;

    // index field of the virtual address for the current level
    always_comb begin
        case (r_level)
            LEVEL_W'(0): idx = r_virt[47:39];
            LEVEL_W'(1): idx = r_virt[38:30];
            LEVEL_W'(2): idx = r_virt[29:21];
            default:     idx = r_virt[20:12];
        endcase
    end

    assign slot       = {r_table, idx};
    assign offs       = rdata[PA_W-1:PAGE_OFS_W] - r_pool_base[PA_W-1:PAGE_OFS_W];
    assign link_frame = r_pool_base[PA_W-1:PAGE_OFS_W] + FRAME_W'(r_fresh);
    assign link_entry = {(ENTRY_W-PA_W)'(0), link_frame, LINK_FLAGS};
    assign leaf_entry = {(ENTRY_W-PA_W)'(0), r_phys[PA_W-1:PAGE_OFS_W], PAGE_OFS_W'(0)}
                        | r_flags;

    assign limit_ext = LW'(r_pool_limit);
    assign pages_ext = LW'(TABLE_PAGES);
    assign usable    = (limit_ext > pages_ext) ? pages_ext : limit_ext;

    assign we    = i_cmd.sweep_en | i_cmd.link | i_cmd.leaf;
    assign waddr = i_cmd.sweep_en ? r_sweep : slot;
    always_comb begin
        if (i_cmd.sweep_en) begin
            wdata = '0;
        end else if (i_cmd.link) begin
            wdata = link_entry;
        end else begin
            wdata = leaf_entry;
        end
    end

    fptm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (slot),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= '0;
            r_pool_limit <= POOL_LIMIT_RST;
            r_next_free  <= CW'(1);
            r_sweep      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POOL_BASE:  r_pool_base  <= i_cfg_data;
                    CFG_POOL_LIMIT: r_pool_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.alloc) begin
                r_next_free <= r_next_free + CW'(1);
                r_sweep     <= {r_next_free[PW-1:0], ENTRY_IDX_W'(0)};
            end else if (i_cmd.sweep_en) begin
                r_sweep <= r_sweep + AW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_virt  <= i_virt_addr;
            r_phys  <= i_phys_addr;
            r_flags <= i_page_flags;
            r_level <= '0;
            r_table <= '0;
            r_added <= '0;
        end
        if (i_cmd.alloc) begin
            r_fresh <= r_next_free[PW-1:0];
            r_added <= r_added + ADDED_W'(1);
        end
        if (i_cmd.link) begin
            r_table <= r_fresh;
            r_level <= r_level + LEVEL_W'(1);
        end
        if (i_cmd.follow) begin
            r_table <= offs[PW-1:0];
            r_level <= r_level + LEVEL_W'(1);
        end
        if (i_cmd.finish) begin
            r_status       <= i_cmd.code;
            r_tables_added <= r_added;
            r_inval        <= (i_cmd.code == ST_MAPPED)
                              ? {r_virt[VA_W-1:PAGE_OFS_W], PAGE_OFS_W'(0)} : '0;
        end
    end

    assign o_st.entry_present  = rdata[0];
    assign o_st.pool_full      = LW'(r_next_free) >= usable;
    assign o_st.outside_pool   = offs >= FRAME_W'(TABLE_PAGES);
    assign o_st.sweep_row_last = &r_sweep[ENTRY_IDX_W-1:0];
    assign o_st.sweep_all_last = r_sweep == AW'(DEPTH - 1);
    assign o_st.last_level     = r_level == LEVEL_W'(2);
    assign o_st.out_free       = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_tables_added    = r_tables_added;
    assign o_invalidate_page = r_inval;

    a_next_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= CW'(TABLE_PAGES))
        else $error("next free page ran past the pool");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished item not presented");

endmodule

/* sv/fptm_ctrl.sv */
module fptm_ctrl import fptm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR_ALL,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_CLEAR_PAGE,
        S_LINK,
        S_LEAF,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [STATUS_W-1:0] r_code, n_code;

    always_comb begin
        n_state        = r_state;
        n_code         = r_code;
        o_cmd          = '0;
        o_cmd.code     = r_code;
        case (r_state)
            S_CLEAR_ALL: begin
                o_cmd.sweep_en = 1'b1;
                if (i_st.sweep_all_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (i_st.entry_present) begin
                    if (i_st.outside_pool) begin
                        n_code  = ST_OUTSIDE;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.follow = 1'b1;
                        n_state      = i_st.last_level ? S_LEAF : S_READ;
                    end
                end else if (i_st.pool_full) begin
                    n_code  = ST_EXHAUSTED;
                    n_state = S_DONE;
                end else begin
                    o_cmd.alloc = 1'b1;
                    n_state     = S_CLEAR_PAGE;
                end
            end
            S_CLEAR_PAGE: begin
                o_cmd.sweep_en = 1'b1;
                if (i_st.sweep_row_last) n_state = S_LINK;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = i_st.last_level ? S_LEAF : S_READ;
            end
            S_LEAF: begin
                o_cmd.leaf = 1'b1;
                n_code     = ST_MAPPED;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR_ALL;
            r_code  <= ST_MAPPED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.alloc |-> !i_st.pool_full)
        else $error("table allocated from a full pool");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_st.out_free)
        else $error("result overwrote an untaken item");

endmodule

/* sv/four_level_page_table_mapper_unit.sv */
// Walk: each upper level is read and checked; a missing table is allocated, cleared and linked.
// Then the leaf is written, unless the walk ends early (pool exhausted, link outside the pool).
// Throughput: one request at a time; the next is accepted once the result is in the output
// register, which holds it until taken. The level-by-level walk over the table RAM sets this limit.
// Reset: synchronous active low; afterwards the whole table store is cleared, one entry a cycle,
// during which no item is accepted but config writes are taken.
module four_level_page_table_mapper_unit import fptm_pkg::*; #(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VA_W-1:0]       i_virt_addr,
    input  logic [PA_W-1:0]       i_phys_addr,
    input  logic [FLAGS_W-1:0]    i_page_flags,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [ADDED_W-1:0]    o_tables_added,
    output logic [VA_W-1:0]       o_invalidate_page
);

    t_dp_cmd    cmd;
    t_dp_status st;

    // Sequencer: walks the three upper levels, allocating and clearing missing
    // tables, then writes the leaf unless the walk failed, and hands the item to the output register.
    fptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Datapath: config registers, table RAM, bump allocator, walk registers
    // and the result register.
    fptm_dp #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_virt_addr       (i_virt_addr),
        .i_phys_addr       (i_phys_addr),
        .i_page_flags      (i_page_flags),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_tables_added    (o_tables_added),
        .o_invalidate_page (o_invalidate_page),
        .i_cmd             (cmd),
        .o_st              (st)
    );

endmodule

/* test/four_level_page_table_mapper_unit_tb.sv */
`timescale 1ns / 100ps

module four_level_page_table_mapper_unit_tb;
    import fptm_pkg::*;

    localparam int POOL_PAGES  = TABLE_PAGES_DEF;
    localparam int SLOTS       = 512;
    // A quiet stretch this long outlasts the reset clear and an item adding three tables,
    // so it means the block is stuck.
    localparam int QUIET_LIMIT = 40000;

    localparam logic [PA_W-1:0]    TOP_BASE  = 52'hF_FFFF_FFFF_F000;
    localparam logic [PA_W-1:0]    FAR_BASE  = 52'h8_0000_0000_0000;
    localparam logic [PA_W-1:0]    ALL_PA    = '1;
    localparam logic [VA_W-1:0]    ALL_VA    = '1;
    localparam logic [FLAGS_W-1:0] BIT63_SET = 64'h8000_0000_0000_0001;
    // home path indices for the directed walks
    localparam logic [8:0] HOME_L4 = 9'd5;
    localparam logic [8:0] HOME_L3 = 9'd7;
    localparam logic [8:0] HOME_L2 = 9'd9;

    typedef struct packed {
        logic [VA_W-1:0]    virt;
        logic [PA_W-1:0]    phys;
        logic [FLAGS_W-1:0] flags;
    } t_map_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDED_W-1:0]  added;
        logic [VA_W-1:0]     inval;
    } t_map_res;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_POOL_BASE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [VA_W-1:0]       i_virt_addr  = '0;
    logic [PA_W-1:0]       i_phys_addr  = '0;
    logic [FLAGS_W-1:0]    i_page_flags = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDED_W-1:0]    o_tables_added;
    logic [VA_W-1:0]       o_invalidate_page;

    // Shadow copy of the table pool, the bump allocator and the two registers
    logic [ENTRY_W-1:0] shadow_tables [0:POOL_PAGES*SLOTS-1];
    int                 alloc_cursor;
    logic [PA_W-1:0]    base_mirror;
    logic [LIMIT_W-1:0] limit_mirror;

    t_map_req pending_reqs [$];
    t_map_res expected_res [$];
    t_map_req on_wire;
    t_map_res want_res;

    int items_loaded = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int error_count  = 0;
    int n_mapped     = 0;
    int n_exhausted  = 0;
    int n_outside    = 0;
    int tables_total = 0;
    int send_gap     = 0;
    int stall_gap    = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    logic [8:0] alt_l4, alt_l3, alt_l2;

    always #5 i_clk = ~i_clk;

    four_level_page_table_mapper_unit #(
        .TABLE_PAGES(POOL_PAGES)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_virt_addr       (i_virt_addr),
        .i_phys_addr       (i_phys_addr),
        .i_page_flags      (i_page_flags),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_tables_added    (o_tables_added),
        .o_invalidate_page (o_invalidate_page)
    );

    // Physical address of pool page n under the current base, wrapped to 52 bits
    function automatic logic [PA_W-1:0] pool_page_addr(int page);
        return {base_mirror[PA_W-1:PAGE_OFS_W], PAGE_OFS_W'(0)} + (PA_W'(page) << PAGE_OFS_W);
    endfunction

    // Walk the shadow tables for one request, allocate missing levels, write the leaf
    function automatic t_map_res predict_walk(t_map_req req);
        logic [VA_W-1:0]    va;
        logic [PA_W-1:0]    frame;
        logic [PA_W-1:0]    offs;
        logic [ENTRY_W-1:0] link;
        int                 tbl;
        int                 slot;
        int                 lvl;
        int                 e;
        int                 usable;
        t_map_res           res;
        va     = {req.virt[VA_W-1:PAGE_OFS_W], PAGE_OFS_W'(0)};
        frame  = {req.phys[PA_W-1:PAGE_OFS_W], PAGE_OFS_W'(0)};
        usable = (limit_mirror > POOL_PAGES) ? POOL_PAGES : int'(limit_mirror);
        tbl    = 0;
        res.status = ST_MAPPED;
        res.added  = '0;
        for (lvl = 0; lvl < 3 && res.status == ST_MAPPED; lvl++) begin
            slot = tbl * SLOTS + int'((va >> (39 - 9 * lvl)) & 48'h1FF);
            link = shadow_tables[slot];
            if (!link[0]) begin
                if (alloc_cursor >= usable) begin
                    res.status = ST_EXHAUSTED;
                end else begin
                    for (e = 0; e < SLOTS; e++)
                        shadow_tables[alloc_cursor * SLOTS + e] = '0;
                    shadow_tables[slot] = {{(ENTRY_W-PA_W){1'b0}}, pool_page_addr(alloc_cursor)}
                                          | ENTRY_W'(LINK_FLAGS);
                    tbl = alloc_cursor;
                    alloc_cursor++;
                    res.added = res.added + ADDED_W'(1);
                end
            end else begin
                // only the frame bits of a present entry point at the next table
                offs = {link[PA_W-1:PAGE_OFS_W], PAGE_OFS_W'(0)}
                     - {base_mirror[PA_W-1:PAGE_OFS_W], PAGE_OFS_W'(0)};
                if (offs[PA_W-1:PAGE_OFS_W] >= POOL_PAGES)
                    res.status = ST_OUTSIDE;
                else
                    tbl = int'(offs[PA_W-1:PAGE_OFS_W]);
            end
        end
        if (res.status == ST_MAPPED)
            shadow_tables[tbl * SLOTS + int'(va[20:12])] = {{(ENTRY_W-PA_W){1'b0}}, frame}
                                                           | req.flags;
        res.inval = (res.status == ST_MAPPED) ? va : '0;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Request driver: hold the item while stalled, advance after accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_res.push_back(predict_walk(on_wire));
                items_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0 && !calm) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    // start an idle burst
                    send_gap = $urandom_range(0, 18);
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    on_wire = pending_reqs.pop_front();
                    i_virt_addr  <= on_wire.virt;
                    i_phys_addr  <= on_wire.phys;
                    i_page_flags <= on_wire.flags;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each taken result against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_res.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", 64'(o_status), '0);
                end else begin
                    want_res = expected_res.pop_front();
                    if (o_status !== want_res.status)
                        flag_mismatch("status", 64'(o_status), 64'(want_res.status));
                    if (o_tables_added !== want_res.added)
                        flag_mismatch("tables_added", 64'(o_tables_added),
                                      64'(want_res.added));
                    if (o_invalidate_page !== want_res.inval)
                        flag_mismatch("invalidate_page", 64'(o_invalidate_page),
                                      64'(want_res.inval));
                    case (want_res.status)
                        ST_MAPPED:    n_mapped++;
                        ST_EXHAUSTED: n_exhausted++;
                        default:      n_outside++;
                    endcase
                    tables_total += int'(want_res.added);
                end
            end
            if (stall_gap > 0 && !calm) begin
                stall_gap--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_gap = $urandom_range(0, 18);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run after a long stretch with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t watchdog expired: %0d items taken, %0d results seen",
                     $time, items_taken, results_seen);
            $display("four_level_page_table_mapper_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_POOL_BASE)
            base_mirror = val;
        else
            limit_mirror = val[LIMIT_W-1:0];
    endtask

    task automatic queue_req(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                             input logic [FLAGS_W-1:0] fl);
        t_map_req req;
        req.virt  = va;
        req.phys  = pa;
        req.flags = fl;
        pending_reqs.push_back(req);
        items_loaded++;
    endtask

    // Wait until every queued item has come back, then let the block settle
    task automatic drain();
        do
            @(posedge i_clk);
        while (pending_reqs.size() != 0 || results_seen < items_loaded);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [VA_W-1:0] make_va(logic [8:0] l4, logic [8:0] l3, logic [8:0] l2,
                                                logic [8:0] l1, logic [11:0] ofs);
        return {l4, l3, l2, l1, ofs};
    endfunction

    // Mostly walks along a small tree of known prefixes so the pool lasts and
    // lookups go deep; the rest is fully random noise.
    task automatic queue_random(int count);
        logic [8:0]         l4, l3, l2;
        logic [VA_W-1:0]    va;
        logic [PA_W-1:0]    pa;
        logic [FLAGS_W-1:0] fl;
        for (int n = 0; n < count; n++) begin
            fl = {$urandom, $urandom};
            if ($urandom_range(0, 9) < 8) begin
                l4 = $urandom_range(0, 1) ? HOME_L4 : alt_l4;
                l3 = $urandom_range(0, 1) ? HOME_L3 : alt_l3;
                l2 = $urandom_range(0, 1) ? HOME_L2 : alt_l2;
                va = make_va(l4, l3, l2, 9'($urandom), 12'($urandom));
            end else begin
                va = VA_W'({$urandom, $urandom});
            end
            // some leaves look like table links, so an aliased walk reads them as such
            if ($urandom_range(0, 3) == 0)
                pa = pool_page_addr($urandom_range(0, POOL_PAGES - 1)) | PA_W'(12'($urandom));
            else
                pa = PA_W'({$urandom, $urandom});
            queue_req(va, pa, fl);
        end
    endtask

    initial begin
        int shift_pages;
        for (int s = 0; s < POOL_PAGES * SLOTS; s++)
            shadow_tables[s] = '0;
        alloc_cursor = 1;
        base_mirror  = '0;
        limit_mirror = POOL_LIMIT_RST;
        alt_l4 = $urandom_range(0, 511);
        alt_l3 = $urandom_range(0, 511);
        alt_l2 = $urandom_range(0, 511);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero pool limit: nothing can be allocated, root still walked
        write_reg(CFG_POOL_BASE, '0);
        write_reg(CFG_POOL_LIMIT, CFG_DATA_W'(0));
        queue_req('0, '0, '0);
        queue_req(ALL_VA, ALL_PA, '1);
        drain();
        write_reg(CFG_POOL_LIMIT, CFG_DATA_W'(1));
        queue_req(make_va(HOME_L4, HOME_L3, HOME_L2, 9'd1, 12'h0), 52'h1234_5678, 64'h3);
        drain();

        // Base at the top of the address space so page addresses wrap; room for
        // two tables only, so the first walk runs out partway and keeps what it added
        write_reg(CFG_POOL_BASE, TOP_BASE);
        write_reg(CFG_POOL_LIMIT, CFG_DATA_W'(3));
        queue_req(make_va(HOME_L4, HOME_L3, HOME_L2, 9'd1, 12'h123), ALL_PA, BIT63_SET);
        queue_req(make_va(HOME_L4, HOME_L3, 9'd300, 9'd1, 12'h0), 52'hABC_DEF0_1000, '0);
        drain();

        // Limit above the pool size clamps to the pool
        write_reg(CFG_POOL_LIMIT, CFG_DATA_W'(31));
        queue_req(make_va(HOME_L4, HOME_L3, HOME_L2, 9'd1, 12'hFFF), 52'h5_5555_5555_5000, '0);
        queue_req(make_va(HOME_L4, HOME_L3, HOME_L2, 9'd511, 12'h0), ALL_PA, '1);
        queue_req(make_va(HOME_L4, HOME_L3, 9'd300, 9'd0, 12'h0), 52'h1000, 64'h7);
        queue_req(make_va(HOME_L4, 9'd400, HOME_L2, 9'd2, 12'h0), 52'hA_AAAA_AAAA_A000, 64'h3);
        // leaf holding a pool page address with bit 63 set
        queue_req(make_va(HOME_L4, HOME_L3, HOME_L2, 9'd1, 12'h0), pool_page_addr(3), BIT63_SET);
        drain();

        // Shift the base by one page: links now alias to their neighbor pages
        write_reg(CFG_POOL_BASE, '0);
        queue_req(make_va(HOME_L4, HOME_L3, HOME_L2, 9'd1, 12'h0), 52'h2_0000_0000, 64'h1);
        drain();
        // Base far away: the first present link lands outside the pool
        write_reg(CFG_POOL_BASE, FAR_BASE);
        queue_req(make_va(HOME_L4, HOME_L3, HOME_L2, 9'd1, 12'h0), 52'h3_0000_0000, 64'h1);
        drain();

        // Random phases over several register settings
        write_reg(CFG_POOL_BASE, TOP_BASE);
        write_reg(CFG_POOL_LIMIT, CFG_DATA_W'(31));
        queue_random(150);
        drain();

        shift_pages = $urandom_range(1, 3);
        write_reg(CFG_POOL_BASE, TOP_BASE + (PA_W'(shift_pages) << PAGE_OFS_W));
        write_reg(CFG_POOL_LIMIT, CFG_DATA_W'($urandom_range(0, 31)));
        queue_random(60);
        drain();

        write_reg(CFG_POOL_BASE, TOP_BASE);
        write_reg(CFG_POOL_LIMIT, CFG_DATA_W'(POOL_LIMIT_RST));
        queue_random(140);
        drain();

        // Last stretch runs back to back on both sides
        write_reg(CFG_POOL_LIMIT, CFG_DATA_W'(31));
        calm = 1'b1;
        queue_random(100);
        drain();
        repeat (20) @(posedge i_clk);

        if (expected_res.size() != 0)
            flag_mismatch("results never delivered", 64'(expected_res.size()), '0);

        $display("%0d requests checked: %0d mapped, %0d pool exhausted, %0d outside pool",
                 results_seen, n_mapped, n_exhausted, n_outside);
        $display("%0d tables added; pool limits 0 to 31, wrapped and shifted pool bases",
                 tables_total);
        if (error_count == 0)
            $display("four_level_page_table_mapper_unit: match");
        else
            $display("four_level_page_table_mapper_unit: mismatch");
        $finish;
    end

endmodule
